// ===== design/gamepad_spi_poll_sequencer_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GAMEPAD_SPI_POLL_SEQUENCER_TOP_DEFINES_SVH
`define GAMEPAD_SPI_POLL_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GSPS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gsps check failed");

// Next-cycle implication, disabled while reset is high.
`define GSPS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gsps check failed");

`endif

// ===== design/gsps_pkg.sv =====
package gsps_pkg;

   localparam int TICK_COUNT_WIDTH_DEF = 16;

   localparam int HALF_WIDTH = 8;
   localparam int GAP_WIDTH  = 16;
   localparam int CSR_WIDTH  = 16;

   localparam logic [HALF_WIDTH-1:0] HALF_PERIOD_RESET = 8'd16;
   localparam logic [GAP_WIDTH-1:0]  ATT_GAP_RESET     = 16'd1;

   // Configuration register indexes
   localparam logic CSR_HALF_PERIOD = 1'b0;
   localparam logic CSR_ATT_GAP     = 1'b1;

   // Pin vector bit positions
   localparam int PIN_CMD = 0;
   localparam int PIN_CLK = 1;
   localparam int PIN_ATT = 2;

   // Frame kinds
   localparam logic [1:0] FRAME_CFG_ENTER = 2'd0;
   localparam logic [1:0] FRAME_POLL      = 2'd3;

   localparam logic [7:0] FRAME_TABLE [32] = '{
      8'h01, 8'h43, 8'h00, 8'h01, 8'h00,
      8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A,
      8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };
   localparam logic [4:0] FRAME_START [4] = '{5'd0, 5'd5, 5'd14, 5'd23};
   localparam logic [3:0] FRAME_LEN   [4] = '{4'd5, 4'd9, 4'd9, 4'd9};

   function automatic logic cmd_bit(input logic [1:0] frame,
                                    input logic [3:0] byte_pos,
                                    input logic [2:0] bit_pos);
      logic [4:0] idx;
      logic [7:0] value;
      idx   = FRAME_START[frame] + {1'b0, byte_pos};
      value = FRAME_TABLE[idx];
      return value[bit_pos];
   endfunction

endpackage

// ===== design/gamepad_spi_poll_sequencer_top.sv =====
// Game-controller serial link master, one timing tick per req transaction.
// req channel: tdata[0] is the sampled controller data line; tdata[7:1] zero.
// rsp channel: one transaction per accepted tick with the pin levels after
//   that tick, the received byte when one completes (tuser[0]), the frame
//   kind in tuser[2:1] and tlast on the last byte of a frame.
// csr port: index 0 half period ticks, index 1 attention gap ticks; write
//   only while the block is idle.
// rsp valid rises in the cycle after req acceptance. Throughput is one tick
// per cycle while the output is not stalled: the sequencer state updates in
// a single pass and the result lands in one output register.
// When rsp_tready is low and the output register is full, req_tready drops
// and the tick is held upstream; nothing is lost or repeated.
// Synchronous reset puts the link idle with attention and clock high,
// command low, the first setup frame selected and the output register
// empty. The frame sequence is config enter, analog on, config exit, then
// the nine-byte poll frame forever.
module gamepad_spi_poll_sequencer_top #(
   parameter int TICK_COUNT_WIDTH = gsps_pkg::TICK_COUNT_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,   // [0] data_in
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // [0] cmd_out, [1] clk_out,
                                                       // [2] att_out, [10:3] rx_byte
   output logic                           rsp_tlast,   // frame_last
   output logic [2:0]                     rsp_tuser,   // [0] rx_valid, [2:1] frame_kind
   input  logic                           csr_we,
   input  logic                           csr_addr,
   input  logic [gsps_pkg::CSR_WIDTH-1:0] csr_wdata
);

   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_ACTIVE = 2'd1;
   localparam int CMP_WIDTH = (TICK_COUNT_WIDTH + 1 > gsps_pkg::GAP_WIDTH + 1) ?
                              TICK_COUNT_WIDTH + 1 : gsps_pkg::GAP_WIDTH + 1;

   logic [gsps_pkg::HALF_WIDTH-1:0] half_ff;
   logic [gsps_pkg::GAP_WIDTH-1:0]  gap_ff;

   logic [1:0]                  frame_ff, frame_in;
   logic [3:0]                  byte_ff, byte_in;
   logic [2:0]                  bit_ff, bit_in;
   logic                        phase_ff, phase_in;
   logic [TICK_COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [7:0]                  shift_ff, shift_in;
   logic [1:0]                  mode_ff, mode_in;
   logic [2:0]                  pins_ff, pins_in;

   logic                        out_valid_ff;
   logic [2:0]                  out_pins_ff;
   logic [7:0]                  out_byte_ff;
   logic                        out_rxv_ff, out_last_ff;
   logic [1:0]                  out_kind_ff;

   logic                        accept;
   logic                        din;
   logic [gsps_pkg::GAP_WIDTH-1:0] limit;
   logic [CMP_WIDTH-1:0]        limit_ext, tick_next_ext;
   logic                        done;
   logic                        rx_valid, rx_last;
   logic [7:0]                  rx_byte;

   assign req_tready = !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign din        = req_tdata[0];

   // Phase end: a zero limit counts as one, and a full counter ends the phase.
   always_comb begin
      if (mode_ff == MODE_ACTIVE) begin
         limit = {{(gsps_pkg::GAP_WIDTH - gsps_pkg::HALF_WIDTH){1'b0}}, half_ff};
      end else begin
         limit = gap_ff;
      end
      if (limit == '0) begin
         limit = {{(gsps_pkg::GAP_WIDTH - 1){1'b0}}, 1'b1};
      end
      limit_ext     = CMP_WIDTH'(limit);
      tick_next_ext = CMP_WIDTH'(tick_ff) + CMP_WIDTH'(1);
      done          = (tick_next_ext >= limit_ext) || (tick_ff == '1);
      tick_in       = done ? '0 : TICK_COUNT_WIDTH'(tick_next_ext);
   end

   always_comb begin
      frame_in = frame_ff;
      byte_in  = byte_ff;
      bit_in   = bit_ff;
      phase_in = phase_ff;
      shift_in = shift_ff;
      mode_in  = mode_ff;
      pins_in  = pins_ff;
      rx_valid = 1'b0;
      rx_last  = 1'b0;
      rx_byte  = '0;
      if (mode_ff != MODE_ACTIVE) begin
         pins_in = 3'b110;
         if (done) begin
            mode_in  = MODE_ACTIVE;
            byte_in  = '0;
            bit_in   = '0;
            shift_in = '0;
            phase_in = 1'b0;
            pins_in  = {2'b00, gsps_pkg::cmd_bit(frame_ff, 4'd0, 3'd0)};
         end
      end else if (!phase_ff) begin
         if (done) begin
            shift_in                    = shift_ff;
            shift_in[bit_ff]            = shift_ff[bit_ff] | din;
            pins_in[gsps_pkg::PIN_CLK]  = 1'b1;
            phase_in                    = 1'b1;
         end
      end else if (done) begin
         if (bit_ff != 3'd7) begin
            bit_in   = bit_ff + 3'd1;
            phase_in = 1'b0;
            pins_in  = {2'b00, gsps_pkg::cmd_bit(frame_ff, byte_ff, bit_ff + 3'd1)};
         end else begin
            rx_valid = 1'b1;
            rx_byte  = shift_ff;
            if ({1'b0, byte_ff} + 5'd1 >= {1'b0, gsps_pkg::FRAME_LEN[frame_ff]}) begin
               rx_last  = 1'b1;
               mode_in  = MODE_IDLE;
               byte_in  = '0;
               bit_in   = '0;
               phase_in = 1'b0;
               pins_in  = 3'b110;
               if (frame_ff != gsps_pkg::FRAME_POLL) begin
                  frame_in = frame_ff + 2'd1;
               end
            end else begin
               byte_in  = byte_ff + 4'd1;
               bit_in   = '0;
               shift_in = '0;
               phase_in = 1'b0;
               pins_in  = {2'b00, gsps_pkg::cmd_bit(frame_ff, byte_ff + 4'd1, 3'd0)};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= gsps_pkg::HALF_PERIOD_RESET;
         gap_ff  <= gsps_pkg::ATT_GAP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            gsps_pkg::CSR_HALF_PERIOD: half_ff <= csr_wdata[gsps_pkg::HALF_WIDTH-1:0];
            gsps_pkg::CSR_ATT_GAP:     gap_ff  <= csr_wdata[gsps_pkg::GAP_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= gsps_pkg::FRAME_CFG_ENTER;
         byte_ff  <= '0;
         bit_ff   <= '0;
         phase_ff <= 1'b0;
         tick_ff  <= '0;
         shift_ff <= '0;
         mode_ff  <= MODE_IDLE;
         pins_ff  <= 3'b110;
      end else if (accept) begin
         frame_ff <= frame_in;
         byte_ff  <= byte_in;
         bit_ff   <= bit_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
         mode_ff  <= mode_in;
         pins_ff  <= pins_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Payload: load on every accepted tick, otherwise hold.
   always_ff @(posedge clock) begin
      if (accept) begin
         out_pins_ff <= pins_in;
         out_byte_ff <= rx_byte;
         out_rxv_ff  <= rx_valid;
         out_last_ff <= rx_last;
         out_kind_ff <= frame_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b00000, out_byte_ff, out_pins_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_kind_ff, out_rxv_ff};

endmodule

// ===== design/gsps_checker.sv =====
`include "gamepad_spi_poll_sequencer_top_defines.svh"

module gsps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [2:0]  rsp_tuser
);

   // A stalled result holds its payload.
   `GSPS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // An empty output register never blocks the input.
   `GSPS_ASSERT_NOW(a_ready_when_empty, !rsp_tvalid, req_tready)

   // Frame end only comes with a received byte, and attention high.
   `GSPS_ASSERT_NOW(a_last_has_byte, rsp_tvalid && rsp_tlast, rsp_tuser[0] && rsp_tdata[2])

   // No byte reported means the byte field is zero.
   `GSPS_ASSERT_NOW(a_idle_byte_zero, rsp_tvalid && !rsp_tuser[0], rsp_tdata[10:3] == 8'h00)

endmodule

bind gamepad_spi_poll_sequencer_top gsps_checker u_gsps_checker (.*);

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TICK_W = gsps_pkg::TICK_COUNT_WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_START = 40;
   localparam int HOLD_END = 140;

   // Command bytes of the four frames, back to back
   localparam logic [7:0] CMD_ROM [32] = '{
      8'h01, 8'h43, 8'h00, 8'h01, 8'h00,
      8'h01, 8'h44, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h01, 8'h43, 8'h00, 8'h00, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A,
      8'h01, 8'h42, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };
   localparam logic [4:0] FRAME_BASE [4] = '{5'd0, 5'd5, 5'd14, 5'd23};
   localparam int FRAME_BYTES [4] = '{5, 9, 9, 9};
   localparam logic [2:0] PINS_IDLE =
      (3'b1 << gsps_pkg::PIN_CLK) | (3'b1 << gsps_pkg::PIN_ATT);

   // Per phase: half period write, attention gap write, ticks, sender idle %, receiver stall %
   localparam int PHASES = 7;
   localparam int PRESSURE_PHASE = 1;
   localparam logic [15:0] PH_HALF [PHASES] =
      '{16'hFF00, 16'h0001, 16'h0002, 16'h0001, 16'h0003, 16'h00FF, 16'hAB01};
   localparam logic [15:0] PH_GAP [PHASES] =
      '{16'h0000, 16'h0002, 16'h0003, 16'h0001, 16'h0005, 16'hFFFF, 16'h0007};
   localparam int PH_TICKS [PHASES] = '{25, 300, 300, 300, 250, 200, 200};
   localparam int PH_SRC_PCT [PHASES] = '{0, 0, 68, 0, 9, 0, 68};
   localparam int PH_SNK_PCT [PHASES] = '{0, 0, 0, 68, 9, 0, 0};
   // Seventeen ones fill the first received byte, then a mixed tail
   localparam logic [24:0] DIRECTED_TICKS = 25'h0AD_FFFF;

   typedef struct packed {
      logic       cmd;
      logic       clk;
      logic       att;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       last;
      logic [1:0] kind;
   } link_sample_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata = '0;      // [0] data_in
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [15:0]                    rsp_tdata;           // [0] cmd_out, [1] clk_out,
                                                        // [2] att_out, [10:3] rx_byte
   logic                           rsp_tlast;
   logic [2:0]                     rsp_tuser;           // [0] rx_valid, [2:1] frame_kind
   logic                           csr_we = 1'b0;
   logic                           csr_addr = 1'b0;
   logic [gsps_pkg::CSR_WIDTH-1:0] csr_wdata = '0;

   logic            data_line_ticks [$];
   link_sample_type expected_link_states [$];
   int              cur_phase = 0;
   int              src_idle_pct = 0;
   int              snk_stall_pct = 0;
   int              hold_age = 0;
   int              quiet_cycles = 0;
   int              mismatches = 0;

   // Predicted sequencer state
   logic [7:0]        half_cfg;
   logic [15:0]       gap_cfg;
   logic [1:0]        frame_sel;
   logic [3:0]        byte_pos;
   logic [2:0]        bit_pos;
   logic              clk_high;
   logic [TICK_W-1:0] tick_cnt;
   logic [7:0]        rx_shift;
   logic              link_active;
   logic [2:0]        pins;

   gamepad_spi_poll_sequencer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A zero limit counts as one; a saturated counter ends the phase too
   function automatic logic tick_expired(input logic [15:0] limit);
      logic [32:0] span;
      span = (limit == '0) ? 33'd1 : 33'(limit);
      if (33'(tick_cnt) + 33'd1 >= span || tick_cnt == '1) begin
         tick_cnt = '0;
         return 1'b1;
      end
      tick_cnt = tick_cnt + 1'b1;
      return 1'b0;
   endfunction

   // Drop clock and attention, put the next command bit on the line
   function automatic void begin_bit();
      logic [7:0] cmd_byte;
      cmd_byte = CMD_ROM[5'(FRAME_BASE[frame_sel] + byte_pos)];
      clk_high = 1'b0;
      pins = '0;
      pins[gsps_pkg::PIN_CMD] = cmd_byte[bit_pos];
   endfunction

   function automatic link_sample_type advance_link(input logic din);
      link_sample_type s;
      s = '0;
      s.kind = frame_sel;
      if (!link_active) begin
         pins = PINS_IDLE;
         if (tick_expired(gap_cfg)) begin
            link_active = 1'b1;
            byte_pos = '0;
            bit_pos = '0;
            rx_shift = '0;
            begin_bit();
         end
      end else if (!clk_high) begin
         if (tick_expired({8'd0, half_cfg})) begin
            rx_shift = rx_shift | (8'(din) << bit_pos);
            pins[gsps_pkg::PIN_CLK] = 1'b1;
            clk_high = 1'b1;
         end
      end else if (tick_expired({8'd0, half_cfg})) begin
         if (bit_pos != 3'd7) begin
            bit_pos = bit_pos + 1'b1;
            begin_bit();
         end else begin
            s.rx_valid = 1'b1;
            s.rx_byte = rx_shift;
            if (int'(byte_pos) + 1 >= FRAME_BYTES[frame_sel]) begin
               s.last = 1'b1;
               link_active = 1'b0;
               byte_pos = '0;
               bit_pos = '0;
               clk_high = 1'b0;
               pins = PINS_IDLE;
               // poll frame repeats forever
               if (frame_sel != gsps_pkg::FRAME_POLL)
                  frame_sel = frame_sel + 1'b1;
            end else begin
               byte_pos = byte_pos + 1'b1;
               bit_pos = '0;
               rx_shift = '0;
               begin_bit();
            end
         end
      end
      s.cmd = pins[gsps_pkg::PIN_CMD];
      s.clk = pins[gsps_pkg::PIN_CLK];
      s.att = pins[gsps_pkg::PIN_ATT];
      return s;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Driver: offer the next tick once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (data_line_ticks.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= {7'd0, data_line_ticks.pop_front()};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off in the pressure phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (cur_phase == PRESSURE_PHASE && hold_age < HOLD_END)
            hold_age <= hold_age + 1;
         if (cur_phase == PRESSURE_PHASE && hold_age >= HOLD_START && hold_age < HOLD_END)
            rsp_tready <= 1'b0;
         else
            rsp_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // Monitor: track register writes, predict each accepted tick, check results
   always @(posedge clock) begin : watch_link
      link_sample_type want;
      if (reset) begin
         half_cfg = gsps_pkg::HALF_PERIOD_RESET;
         gap_cfg = gsps_pkg::ATT_GAP_RESET;
         frame_sel = gsps_pkg::FRAME_CFG_ENTER;
         byte_pos = '0;
         bit_pos = '0;
         clk_high = 1'b0;
         tick_cnt = '0;
         rx_shift = '0;
         link_active = 1'b0;
         pins = PINS_IDLE;
      end else begin
         if (csr_we) begin
            if (csr_addr == gsps_pkg::CSR_HALF_PERIOD)
               half_cfg = csr_wdata[gsps_pkg::HALF_WIDTH-1:0];
            else if (csr_addr == gsps_pkg::CSR_ATT_GAP)
               gap_cfg = csr_wdata[gsps_pkg::GAP_WIDTH-1:0];
         end
         if (req_tvalid && req_tready)
            expected_link_states.push_back(advance_link(req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_link_states.size() == 0) begin
               $display("%0t: rsp transaction with nothing expected, actual tdata %0h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_link_states.pop_front();
               check_field("cmd_out", want.cmd, rsp_tdata[gsps_pkg::PIN_CMD]);
               check_field("clk_out", want.clk, rsp_tdata[gsps_pkg::PIN_CLK]);
               check_field("att_out", want.att, rsp_tdata[gsps_pkg::PIN_ATT]);
               check_field("rx_byte", want.rx_byte, rsp_tdata[10:3]);
               check_field("rx_valid", want.rx_valid, rsp_tuser[0]);
               check_field("frame_last", want.last, rsp_tlast);
               check_field("frame_kind", want.kind, rsp_tuser[2:1]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic idx, input logic [gsps_pkg::CSR_WIDTH-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
   endtask

   initial begin : stimulus
      int  run_left;
      int  run_mode;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      run_left = 0;
      run_mode = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         // hold until every transaction of the last phase has come back
         do @(negedge clock);
         while (data_line_ticks.size() != 0 || req_tvalid || expected_link_states.size() != 0);
         repeat (2) @(posedge clock);
         write_csr(gsps_pkg::CSR_HALF_PERIOD, PH_HALF[ph]);
         write_csr(gsps_pkg::CSR_ATT_GAP, PH_GAP[ph]);
         @(posedge clock);
         csr_we <= 1'b0;
         cur_phase <= ph;
         src_idle_pct <= PH_SRC_PCT[ph];
         snk_stall_pct <= PH_SNK_PCT[ph];
         for (int n = 0; n < PH_TICKS[ph]; n++) begin
            if (ph == 0) begin
               data_line_ticks.push_back(DIRECTED_TICKS[n]);
            end else begin
               // runs of a stuck line give all-zero and all-one bytes
               if (run_left == 0) begin
                  run_left = $urandom_range(1, 40);
                  run_mode = $urandom_range(2);
               end
               run_left--;
               data_line_ticks.push_back(run_mode == 2 ? 1'($urandom) : run_mode[0]);
            end
         end
      end
      do @(negedge clock);
      while (data_line_ticks.size() != 0 || req_tvalid || expected_link_states.size() != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
